// ----- rtl/assert_macros.svh -----
// Assertion helpers; all use clk_i and the active-low rst_ni of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

// ----- rtl/igbc_pkg.sv -----
package igbc_pkg;

  localparam int AXES    = 3;
  localparam int BIAS_W  = 32;
  localparam int RATE_W  = 33;
  localparam int LIMIT_W = 15;
  localparam int CALIB_W = 16;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;
  localparam int STEP_W  = 3;

  localparam logic [CIDX_W-1:0] CFG_ACCEL_LIMIT   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_GYRO_LIMIT    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_CALIB_SAMPLES = 2'd2;

  localparam logic [LIMIT_W-1:0] ACCEL_LIMIT_RST   = 15'd32767;
  localparam logic [LIMIT_W-1:0] GYRO_LIMIT_RST    = 15'd32767;
  localparam logic [CALIB_W-1:0] CALIB_SAMPLES_RST = 16'd1000;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_WAIT   = 3'd0;
  localparam step_t ST_DECIDE = 3'd1;
  localparam step_t ST_DIV    = 3'd2;
  localparam step_t ST_UPDATE = 3'd3;
  localparam step_t ST_EMIT   = 3'd4;

  typedef enum logic [2:0] {
    OP_WAIT   = 3'd0,
    OP_DECIDE = 3'd1,
    OP_DIV    = 3'd2,
    OP_UPDATE = 3'd3,
    OP_EMIT   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_ACCEPT    = 3'd1,
    C_CAL_DONE  = 3'd2,
    C_ITER_ZERO = 3'd3,
    C_OUT_FREE  = 3'd4
  } cond_e;

  typedef enum logic {
    MISS_HOLD = 1'b0,
    MISS_NEXT = 1'b1
  } miss_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
    miss_e miss;
  } cw_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  // Control store: on a true condition jump to target, otherwise hold or fall through.
  function automatic cw_t ucode(input step_t step);
    cw_t cw;
    unique case (step)
      ST_WAIT:   cw = '{op: OP_WAIT,   cond: C_ACCEPT,    target: ST_DECIDE, miss: MISS_HOLD};
      ST_DECIDE: cw = '{op: OP_DECIDE, cond: C_CAL_DONE,  target: ST_EMIT,   miss: MISS_NEXT};
      ST_DIV:    cw = '{op: OP_DIV,    cond: C_ITER_ZERO, target: ST_UPDATE, miss: MISS_HOLD};
      ST_UPDATE: cw = '{op: OP_UPDATE, cond: C_ALWAYS,    target: ST_EMIT,   miss: MISS_NEXT};
      ST_EMIT:   cw = '{op: OP_EMIT,   cond: C_OUT_FREE,  target: ST_WAIT,   miss: MISS_HOLD};
      default:   cw = '{op: OP_WAIT,   cond: C_ALWAYS,    target: ST_WAIT,   miss: MISS_HOLD};
    endcase
    return cw;
  endfunction

endpackage

// ----- rtl/igbc_div_lane.sv -----
module igbc_div_lane #(
  parameter int DIVIDEND_W = 33,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  igbc_pkg::div_ctrl_t   ctrl_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // Restoring division, one quotient bit per step, MSB first.
  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    fits    = !trial[DIVISOR_W];
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (ctrl_i.load) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (ctrl_i.step) begin
      rem_d = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      quo_q <= '0;
      dvs_q <= '0;
    end else begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      dvs_q <= dvs_d;
    end
  end

  assign quotient_o = quo_q;

endmodule

// ----- rtl/imu_gyro_bias_calib_and_clamp_core.sv -----
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: accel x,y,z, rate x,y,z (SAMPLE_BITS each)
// m_axis    out  tvalid/tready          tdata: accel out x,y,z, rate out x,y,z; tuser: calibrating
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data (always ready)
//
// Calibrating item: wait, decide, divide, update and emit steps; the divide step repeats
// in the bit-serial divide loop that steps all three axis lanes together.
// Working item: wait, decide and emit steps.
// Reset clears bias, sample count, working flag and the registers to their defaults.
// A full output register stalls the emit step; the next item is taken while a result waits.
module imu_gyro_bias_calib_and_clamp_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
  input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // accel_out_x, accel_out_y, accel_out_z, rate_out_x, rate_out_y, rate_out_z
  output logic [((3*SAMPLE_BITS+3*igbc_pkg::RATE_W+7)/8)*8-1:0] m_axis_tdata_o,
  // calibrating
  output logic [0:0]                         m_axis_tuser_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [igbc_pkg::CIDX_W-1:0]        cfg_index_i,
  input  logic [igbc_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int SW        = SAMPLE_BITS;
  localparam int BW        = igbc_pkg::BIAS_W;
  localparam int RW        = igbc_pkg::RATE_W;
  localparam int LW        = igbc_pkg::LIMIT_W;
  localparam int PROD_W    = SAMPLE_BITS + FRAC_BITS;
  localparam int DIFF_W    = ((PROD_W > BW) ? PROD_W : BW) + 1;
  localparam int SUM_W     = DIFF_W + 2;
  localparam int ITER_W    = $clog2(DIFF_W);
  localparam int CMP_W     = ((SW > LW) ? SW : LW) + 1;
  localparam int CNT_CMP_W = ((COUNT_BITS > igbc_pkg::CALIB_W) ? COUNT_BITS
                                                               : igbc_pkg::CALIB_W) + 1;

  // Configuration registers
  logic [LW-1:0]                accel_lim_q;
  logic [LW-1:0]                gyro_lim_q;
  logic [igbc_pkg::CALIB_W-1:0] calib_q;

  // Sequencer
  igbc_pkg::step_t step_q, step_d;
  igbc_pkg::cw_t   cw;
  logic            cond_hit;
  logic [ITER_W-1:0] iter_q, iter_d;

  // Datapath state
  logic signed [SW-1:0] accel_q [igbc_pkg::AXES];
  logic signed [SW-1:0] gyro_q  [igbc_pkg::AXES];
  logic signed [BW-1:0] bias_q  [igbc_pkg::AXES];
  logic signed [BW-1:0] bias_d  [igbc_pkg::AXES];
  logic                 neg_q   [igbc_pkg::AXES];
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                 working_q, working_d;

  // Output register
  logic                 out_valid_q;
  logic signed [SW-1:0] accel_out_q [igbc_pkg::AXES];
  logic signed [RW-1:0] rate_out_q  [igbc_pkg::AXES];
  logic                 calib_out_q;

  // Combinational helpers
  logic                 in_accept;
  logic                 out_free;
  logic                 out_load;
  logic                 cal_done;
  logic                 cap_in;
  logic                 upd_en;
  igbc_pkg::div_ctrl_t  div_ctrl;
  logic [COUNT_BITS-1:0] divisor;
  logic signed [DIFF_W-1:0] diff   [igbc_pkg::AXES];
  logic [DIFF_W-1:0]        mag    [igbc_pkg::AXES];
  logic [DIFF_W-1:0]        quo    [igbc_pkg::AXES];
  logic signed [SW-1:0]     clamp  [igbc_pkg::AXES];
  logic signed [DIFF_W-1:0] gext;
  logic signed [DIFF_W-1:0] bext;
  logic signed [SUM_W-1:0]  qs;
  logic signed [SUM_W-1:0]  sum;
  logic signed [CMP_W-1:0]  a_ext;
  logic signed [CMP_W-1:0]  g_ext;
  logic signed [CMP_W-1:0]  alim;
  logic signed [CMP_W-1:0]  alim_n;
  logic signed [CMP_W-1:0]  glim;
  logic                     reject;

  assign cfg_ready_o     = 1'b1;
  assign cw              = igbc_pkg::ucode(step_q);
  assign s_axis_tready_o = (cw.op == igbc_pkg::OP_WAIT);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign cal_done        = working_q
                        || (CNT_CMP_W'(count_q) >= CNT_CMP_W'(calib_q))
                        || (count_q == {COUNT_BITS{1'b1}});
  assign divisor         = count_q + 1'b1;

  always_comb begin
    case (cw.cond)
      igbc_pkg::C_ALWAYS:    cond_hit = 1'b1;
      igbc_pkg::C_ACCEPT:    cond_hit = in_accept;
      igbc_pkg::C_CAL_DONE:  cond_hit = cal_done;
      igbc_pkg::C_ITER_ZERO: cond_hit = (iter_q == '0);
      igbc_pkg::C_OUT_FREE:  cond_hit = out_free;
      default:               cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_hit) begin
      step_d = cw.target;
    end else if (cw.miss == igbc_pkg::MISS_NEXT) begin
      step_d = igbc_pkg::step_t'(step_q + 1'b1);
    end else begin
      step_d = step_q;
    end
  end

  assign cap_in        = (cw.op == igbc_pkg::OP_WAIT) && in_accept;
  assign div_ctrl.load = (cw.op == igbc_pkg::OP_DECIDE) && !cond_hit;
  assign div_ctrl.step = (cw.op == igbc_pkg::OP_DIV);
  assign upd_en        = (cw.op == igbc_pkg::OP_UPDATE);
  assign out_load      = (cw.op == igbc_pkg::OP_EMIT) && out_free;

  always_comb begin
    iter_d = iter_q;
    if (div_ctrl.load) begin
      iter_d = ITER_W'(DIFF_W - 1);
    end else if (div_ctrl.step) begin
      iter_d = iter_q - 1'b1;
    end
  end

  always_comb begin
    working_d = working_q;
    if ((cw.op == igbc_pkg::OP_DECIDE) && cond_hit) begin
      working_d = 1'b1;
    end
  end

  assign count_d = upd_en ? count_q + 1'b1 : count_q;

  // Per-axis raw * 2^FRAC_BITS - bias, split into sign and magnitude for the lanes.
  always_comb begin
    gext = '0;
    bext = '0;
    for (int a = 0; a < igbc_pkg::AXES; a++) begin
      gext    = {{(DIFF_W-SW){gyro_q[a][SW-1]}}, gyro_q[a]};
      bext    = {{(DIFF_W-BW){bias_q[a][BW-1]}}, bias_q[a]};
      diff[a] = (gext <<< FRAC_BITS) - bext;
      mag[a]  = diff[a][DIFF_W-1] ? DIFF_W'(-diff[a]) : DIFF_W'(diff[a]);
    end
  end

  for (genvar a = 0; a < igbc_pkg::AXES; a++) begin : g_lane
    igbc_div_lane #(
      .DIVIDEND_W(DIFF_W),
      .DIVISOR_W (COUNT_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (div_ctrl),
      .dividend_i(mag[a]),
      .divisor_i (divisor),
      .quotient_o(quo[a])
    );
  end

  // Bias update with signed-32 saturation; rejected axes hold.
  always_comb begin
    qs     = '0;
    sum    = '0;
    g_ext  = '0;
    reject = 1'b0;
    glim   = {{(CMP_W-LW){1'b0}}, gyro_lim_q};
    for (int a = 0; a < igbc_pkg::AXES; a++) begin
      bias_d[a] = bias_q[a];
      g_ext  = {{(CMP_W-SW){gyro_q[a][SW-1]}}, gyro_q[a]};
      reject = (g_ext > glim) || (g_ext < -glim);
      qs     = {2'b00, quo[a]};
      if (neg_q[a]) begin
        qs = -qs;
      end
      sum = {{(SUM_W-BW){bias_q[a][BW-1]}}, bias_q[a]} + qs;
      if (upd_en && !reject) begin
        if ((sum[SUM_W-1:BW-1] == '0) || (sum[SUM_W-1:BW-1] == '1)) begin
          bias_d[a] = sum[BW-1:0];
        end else if (sum[SUM_W-1]) begin
          bias_d[a] = {1'b1, {(BW-1){1'b0}}};
        end else begin
          bias_d[a] = {1'b0, {(BW-1){1'b1}}};
        end
      end
    end
  end

  always_comb begin
    a_ext  = '0;
    alim   = {{(CMP_W-LW){1'b0}}, accel_lim_q};
    alim_n = -alim;
    for (int a = 0; a < igbc_pkg::AXES; a++) begin
      a_ext = {{(CMP_W-SW){accel_q[a][SW-1]}}, accel_q[a]};
      if (a_ext > alim) begin
        clamp[a] = alim[SW-1:0];
      end else if (a_ext < alim_n) begin
        clamp[a] = alim_n[SW-1:0];
      end else begin
        clamp[a] = accel_q[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_lim_q <= igbc_pkg::ACCEL_LIMIT_RST;
      gyro_lim_q  <= igbc_pkg::GYRO_LIMIT_RST;
      calib_q     <= igbc_pkg::CALIB_SAMPLES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        igbc_pkg::CFG_ACCEL_LIMIT:   accel_lim_q <= cfg_data_i[LW-1:0];
        igbc_pkg::CFG_GYRO_LIMIT:    gyro_lim_q  <= cfg_data_i[LW-1:0];
        igbc_pkg::CFG_CALIB_SAMPLES: calib_q     <= cfg_data_i[igbc_pkg::CALIB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= igbc_pkg::ST_WAIT;
      iter_q      <= '0;
      count_q     <= '0;
      working_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < igbc_pkg::AXES; a++) begin
        bias_q[a] <= '0;
      end
    end else begin
      step_q    <= step_d;
      iter_q    <= iter_d;
      count_q   <= count_d;
      working_q <= working_d;
      for (int a = 0; a < igbc_pkg::AXES; a++) begin
        bias_q[a] <= bias_d[a];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < igbc_pkg::AXES; a++) begin
      if (cap_in) begin
        accel_q[a] <= s_axis_tdata_i[a*SW +: SW];
        gyro_q[a]  <= s_axis_tdata_i[(igbc_pkg::AXES+a)*SW +: SW];
      end
      if (div_ctrl.load) begin
        neg_q[a] <= diff[a][DIFF_W-1];
      end
      if (out_load) begin
        accel_out_q[a] <= clamp[a];
        rate_out_q[a]  <= diff[a][RW-1:0];
      end
    end
    if (out_load) begin
      calib_out_q <= !working_q;
    end
  end

  always_comb begin
    m_axis_tdata_o = '0;
    for (int a = 0; a < igbc_pkg::AXES; a++) begin
      m_axis_tdata_o[a*SW +: SW]                                = accel_out_q[a];
      m_axis_tdata_o[igbc_pkg::AXES*SW + a*RW +: RW]            = rate_out_q[a];
    end
  end

  assign m_axis_tuser_o  = calib_out_q;
  assign m_axis_tvalid_o = out_valid_q;

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_working_sticky, working_q |=> working_q, "working flag cleared")
  `ASSERT_ALWAYS(a_count_frozen, working_q |=> $stable(count_q), "count moved while working")
  `ASSERT_NEVER(a_no_overwrite, out_load && out_valid_q && !m_axis_tready_i, "result overwritten")
  `ASSERT_ALWAYS(a_flag_match, out_load |=> (m_axis_tuser_o[0] == !working_q), "flag mismatch")

endmodule
